// ----- design/rmq_pkg.sv -----
package rmq_pkg;

	localparam int FRAC_BITS = 14;
	localparam int FIELD_W = 16;
	localparam int GUARD_BITS = (32 - FRAC_BITS) / 2;
	localparam int ONE = 1 << FRAC_BITS;

	localparam int T_W = ((FRAC_BITS > 16) ? FRAC_BITS : 16) + 3;
	localparam int RAD_RAW_W = (T_W - 1) + FRAC_BITS + 2 * GUARD_BITS;
	localparam int SQ_W = (RAD_RAW_W + 1) / 2;
	localparam int RAD_W = 2 * SQ_W;
	localparam int REM_W = SQ_W + 2;
	localparam int D_W = SQ_W + 1;
	localparam int NUM_SH = FRAC_BITS + GUARD_BITS;
	localparam int QB = 15;
	localparam int NUM_W = T_W + NUM_SH;
	localparam int DIV_W = (NUM_W > D_W + QB) ? NUM_W : D_W + QB;
	localparam int MO_W = QB + 2;
	localparam int LIM_P = (FRAC_BITS < 15) ? ONE : 32767;
	localparam int LIM_N = (FRAC_BITS < 15) ? ONE : 32768;
	localparam int LATENCY = 3 + SQ_W + QB;

	function automatic logic signed [T_W-1:0] sx(input logic signed [FIELD_W-1:0] v);
		return T_W'(v);
	endfunction

endpackage

// ----- design/rotation_matrix_to_quaternion_unit.sv -----
// Converts one 3x3 rotation matrix (nine signed Q1.14 entries) into a unit
// quaternion q_w, q_x, q_y, q_z in signed Q1.14, using the largest-trace case.
// A matrix is taken as a beat at each rising edge where start is high and busy
// is low. Busy is always low, so a new matrix may be offered in every cycle.
// The quaternion for a matrix appears on the result ports with done high for
// exactly one cycle, after the input register, the square-root stages, the
// division input register, the division stages and the output register.
// Results come out in input order. The square root gives one result bit per
// pipeline stage and the division one quotient bit per pipeline stage.
// When t is not positive the quaternion is zero and not_rotation is high.
// The receiver cannot stall the block; it must take each result as it appears.
// Reset clears every valid bit, so no result appears for items in flight.
module rotation_matrix_to_quaternion_unit
	import rmq_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic signed [FIELD_W-1:0]  m00,
	input  logic signed [FIELD_W-1:0]  m01,
	input  logic signed [FIELD_W-1:0]  m02,
	input  logic signed [FIELD_W-1:0]  m10,
	input  logic signed [FIELD_W-1:0]  m11,
	input  logic signed [FIELD_W-1:0]  m12,
	input  logic signed [FIELD_W-1:0]  m20,
	input  logic signed [FIELD_W-1:0]  m21,
	input  logic signed [FIELD_W-1:0]  m22,
	output logic                       done,
	output logic signed [FIELD_W-1:0]  q_w,
	output logic signed [FIELD_W-1:0]  q_x,
	output logic signed [FIELD_W-1:0]  q_y,
	output logic signed [FIELD_W-1:0]  q_z,
	output logic                       not_rotation
);

	logic                     sq_v_s    [0:SQ_W];
	logic                     sq_nr_s   [0:SQ_W];
	logic [RAD_W-1:0]         sq_rad_s  [0:SQ_W];
	logic [REM_W-1:0]         sq_rem_s  [0:SQ_W];
	logic [SQ_W-1:0]          sq_root_s [0:SQ_W];
	logic signed [T_W-1:0]    sq_c_s    [0:SQ_W][0:3];

	logic                     dv_v_s    [0:QB];
	logic                     dv_nr_s   [0:QB];
	logic [DIV_W-1:0]         dv_d_s    [0:QB];
	logic [DIV_W-1:0]         dv_rem_s  [0:QB][0:3];
	logic [QB-1:0]            dv_q_s    [0:QB][0:3];
	logic                     dv_ovf_s  [0:QB][0:3];
	logic                     dv_neg_s  [0:QB][0:3];

	logic                     out_v_q;
	logic                     out_nr_q;
	logic signed [FIELD_W-1:0] out_q_q  [0:3];

	logic signed [T_W-1:0]    a00, a01, a02, a10, a11, a12, a20, a21, a22, one_t;
	logic signed [T_W-1:0]    t_c;
	logic signed [T_W-1:0]    c_c [0:3];

	assign busy = 1'b0;

	always_comb begin
		a00 = sx(m00); a01 = sx(m01); a02 = sx(m02);
		a10 = sx(m10); a11 = sx(m11); a12 = sx(m12);
		a20 = sx(m20); a21 = sx(m21); a22 = sx(m22);
		one_t = T_W'(ONE);
		if (a22 < 0) begin
			if (a00 > a11) begin
				t_c = one_t + a00 - a11 - a22;
				c_c[0] = a21 - a12; c_c[1] = t_c; c_c[2] = a10 + a01; c_c[3] = a20 + a02;
			end else begin
				t_c = one_t - a00 + a11 - a22;
				c_c[0] = a02 - a20; c_c[1] = a01 + a10; c_c[2] = t_c; c_c[3] = a12 + a21;
			end
		end else begin
			if ((a00 + a11) < 0) begin
				t_c = one_t - a00 - a11 + a22;
				c_c[0] = a10 - a01; c_c[1] = a20 + a02; c_c[2] = a12 + a21; c_c[3] = t_c;
			end else begin
				t_c = one_t + a00 + a11 + a22;
				c_c[0] = t_c; c_c[1] = a21 - a12; c_c[2] = a02 - a20; c_c[3] = a10 - a01;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else begin
			sq_v_s[0] <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sq_nr_s[0]   <= (t_c <= 0);
		sq_rad_s[0]  <= (t_c <= 0) ? '0 : RAD_W'(t_c) << (FRAC_BITS + 2 * GUARD_BITS);
		sq_rem_s[0]  <= '0;
		sq_root_s[0] <= '0;
		for (int i = 0; i < 4; i++) begin
			sq_c_s[0][i] <= c_c[i];
		end
	end

	// Square root, one result bit per stage.
	for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
		logic [REM_W:0]  rem_sh;
		logic [REM_W:0]  trial;
		logic            take;

		always_comb begin
			rem_sh = {sq_rem_s[k][REM_W-2:0], sq_rad_s[k][RAD_W-1 -: 2]};
			trial  = (REM_W+1)'({sq_root_s[k], 2'b01});
			take   = (rem_sh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_nr_s[k+1]   <= sq_nr_s[k];
			sq_rad_s[k+1]  <= sq_rad_s[k] << 2;
			sq_rem_s[k+1]  <= take ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
			sq_root_s[k+1] <= {sq_root_s[k][SQ_W-2:0], take};
			for (int i = 0; i < 4; i++) begin
				sq_c_s[k+1][i] <= sq_c_s[k][i];
			end
		end
	end

	logic [SQ_W-1:0]  s_c;
	logic [DIV_W-1:0] d_c;
	logic [DIV_W-1:0] num_c [0:3];
	logic [T_W-1:0]   mag_c [0:3];

	always_comb begin
		s_c = (sq_root_s[SQ_W] == '0) ? SQ_W'(1) : sq_root_s[SQ_W];
		d_c = DIV_W'({s_c, 1'b0});
		for (int i = 0; i < 4; i++) begin
			mag_c[i] = sq_c_s[SQ_W][i][T_W-1] ? T_W'(-sq_c_s[SQ_W][i]) : T_W'(sq_c_s[SQ_W][i]);
			num_c[i] = (DIV_W'(mag_c[i]) << NUM_SH) + DIV_W'(s_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s[0] <= 1'b0;
		end else begin
			dv_v_s[0] <= sq_v_s[SQ_W];
		end
	end

	always_ff @(posedge clk) begin
		dv_nr_s[0] <= sq_nr_s[SQ_W];
		dv_d_s[0]  <= d_c;
		for (int i = 0; i < 4; i++) begin
			dv_rem_s[0][i] <= num_c[i];
			dv_q_s[0][i]   <= '0;
			dv_ovf_s[0][i] <= (num_c[i] >= (d_c << QB));
			dv_neg_s[0][i] <= sq_c_s[SQ_W][i][T_W-1];
		end
	end

	// Restoring division, one quotient bit per stage, four lanes.
	for (genvar k = 0; k < QB; k++) begin : g_div
		logic [DIV_W-1:0] dsh;

		assign dsh = dv_d_s[k] << (QB - 1 - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[k+1] <= 1'b0;
			end else begin
				dv_v_s[k+1] <= dv_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			dv_nr_s[k+1] <= dv_nr_s[k];
			dv_d_s[k+1]  <= dv_d_s[k];
			for (int i = 0; i < 4; i++) begin
				dv_ovf_s[k+1][i] <= dv_ovf_s[k][i];
				dv_neg_s[k+1][i] <= dv_neg_s[k][i];
				if (dv_rem_s[k][i] >= dsh) begin
					dv_rem_s[k+1][i] <= dv_rem_s[k][i] - dsh;
					dv_q_s[k+1][i]   <= dv_q_s[k][i] | (QB'(1) << (QB - 1 - k));
				end else begin
					dv_rem_s[k+1][i] <= dv_rem_s[k][i];
					dv_q_s[k+1][i]   <= dv_q_s[k][i];
				end
			end
		end
	end

	logic [MO_W-1:0] qm_c  [0:3];
	logic [MO_W-1:0] lim_c [0:3];
	logic [MO_W-1:0] sat_c [0:3];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			qm_c[i]  = MO_W'(dv_q_s[QB][i]);
			lim_c[i] = dv_neg_s[QB][i] ? MO_W'(LIM_N) : MO_W'(LIM_P);
			sat_c[i] = (dv_ovf_s[QB][i] || (qm_c[i] > lim_c[i])) ? lim_c[i] : qm_c[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else begin
			out_v_q <= dv_v_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		out_nr_q <= dv_nr_s[QB];
		for (int i = 0; i < 4; i++) begin
			if (dv_nr_s[QB]) begin
				out_q_q[i] <= '0;
			end else if (dv_neg_s[QB][i]) begin
				out_q_q[i] <= FIELD_W'(-sat_c[i]);
			end else begin
				out_q_q[i] <= FIELD_W'(sat_c[i]);
			end
		end
	end

	assign done         = out_v_q;
	assign not_rotation = out_nr_q;
	assign q_w          = out_q_q[0];
	assign q_x          = out_q_q[1];
	assign q_y          = out_q_q[2];
	assign q_z          = out_q_q[3];

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("Accepted matrix did not produce a result on time.");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("Result appeared without a matching input beat.");

	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && not_rotation) |-> (q_w == 0 && q_x == 0 && q_y == 0 && q_z == 0))
		else $error("Quaternion not cleared for a non-rotation.");

	a_w_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($signed(q_w) <= LIM_P && $signed(q_w) >= -LIM_N))
		else $error("Scalar part left the saturation range.");
`endif

endmodule
